[sv/bwh_pkg.sv]
// bwh_pkg: shared constants, command codes and the memory request struct of the
// binary word histogram. No dependencies; imported by every bwh module.
`default_nettype none

package bwh_pkg;

   // defaults of the top level parameters
   localparam int DEF_MAX_WORD_BITS = 10;
   localparam int DEF_COUNT_BITS    = 32;

   // fixed field widths
   localparam int CMD_W      = 2;
   localparam int SYM_W      = 8;
   localparam int WIDX_W     = 10;
   localparam int LEN_W      = 4;
   localparam int OUT_W      = 32;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   localparam logic [LEN_W-1:0] WORD_LENGTH_RESET = 4'd8;
   localparam logic [SYM_W-1:0] SYM_ZERO          = 8'h30;
   localparam logic [SYM_W-1:0] SYM_ONE           = 8'h31;
   localparam logic [OUT_W-1:0] OUT_MAX           = 32'hFFFF_FFFF;

   // request kinds carried in req_tuser
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH       = 2'd0,
      CMD_READ_WORD  = 2'd1,
      CMD_READ_TOTAL = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   // access issued to the count memory
   typedef struct packed {
      logic rd;    // read the entry this cycle
      logic inc;   // write it back incremented on the next cycle
   } mem_req_type;

endpackage

`default_nettype wire

[sv/bwh_window.sv]
// bwh_window: sliding bit window, fill tracking, bad-symbol error and the
// saturating total of counted windows. Depends on bwh_pkg.
`default_nettype none

module bwh_window #(
   parameter int MAX_WORD_BITS = bwh_pkg::DEF_MAX_WORD_BITS,
   parameter int COUNT_BITS    = bwh_pkg::DEF_COUNT_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [bwh_pkg::SYM_W-1:0]     symbol,
   input  wire logic [bwh_pkg::LEN_W-1:0]     word_length,
   output logic                               count,
   output logic      [MAX_WORD_BITS-1:0]      idx,
   output logic                               error,
   output logic      [COUNT_BITS-1:0]         total
);
   import bwh_pkg::*;

   localparam int FILL_W = $clog2(MAX_WORD_BITS + 1);

   logic [MAX_WORD_BITS-1:0] win_ff, win_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic                     pend_ff, pend_in;
   logic                     error_ff, error_in;
   logic [COUNT_BITS-1:0]    total_ff, total_in;

   logic [LEN_W:0]           wl_ext;
   logic [LEN_W:0]           len_clamp;
   logic [FILL_W-1:0]        len_eff;
   logic [MAX_WORD_BITS-1:0] mask;
   logic                     bit_val, bad, step, complete, pend_next;
   logic [FILL_W-1:0]        fill_next;
   logic [MAX_WORD_BITS-1:0] win_next;

   // effective word length, clamped to 1..MAX_WORD_BITS
   always_comb begin
      wl_ext = {1'b0, word_length};
      if (word_length == '0) begin
         len_clamp = (LEN_W+1)'(1);
      end else if (wl_ext > (LEN_W+1)'(MAX_WORD_BITS)) begin
         len_clamp = (LEN_W+1)'(MAX_WORD_BITS);
      end else begin
         len_clamp = wl_ext;
      end
      len_eff = FILL_W'(len_clamp);
      for (int i = 0; i < MAX_WORD_BITS; i++) begin
         mask[i] = (FILL_W'(i) < len_eff);
      end
   end

   // shift in one symbol and decide whether a window completes
   always_comb begin
      bit_val   = (symbol == SYM_ONE);
      bad       = (symbol != SYM_ONE) && (symbol != SYM_ZERO);
      step      = push && !error_ff;
      win_next  = MAX_WORD_BITS'({win_ff, bit_val});
      fill_next = (fill_ff < FILL_W'(MAX_WORD_BITS)) ? fill_ff + 1'b1 : fill_ff;
      pend_next = pend_ff || bad;
      complete  = (fill_next >= len_eff);
      count     = step && complete && !pend_next;
      idx       = win_next & mask;

      win_in   = win_ff;
      fill_in  = fill_ff;
      pend_in  = pend_ff;
      error_in = error_ff;
      total_in = total_ff;
      if (step) begin
         win_in  = win_next;
         fill_in = fill_next;
         pend_in = pend_next;
         if (complete) begin
            if (pend_next) begin
               error_in = 1'b1;
               pend_in  = 1'b0;
            end else if (total_ff != '1) begin
               total_in = total_ff + 1'b1;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
         error_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         error_ff <= error_in;
         total_ff <= total_in;
      end
   end

   assign error = error_ff;
   assign total = total_ff;

   // sticky error freezes the window
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("error flag dropped without reset");

   a_no_count_after_error: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> !count && $stable(total_ff))
      else $error("window counted after error");

endmodule

`default_nettype wire

[sv/bwh_count_mem.sv]
// bwh_count_mem: word counter memory with registered read, increment
// write-back, same-entry forwarding and a clearing sweep after reset.
// Depends on bwh_pkg.
`default_nettype none

module bwh_count_mem #(
   parameter int MAX_WORD_BITS = bwh_pkg::DEF_MAX_WORD_BITS,
   parameter int COUNT_BITS    = bwh_pkg::DEF_COUNT_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bwh_pkg::mem_req_type       req,
   input  wire logic [MAX_WORD_BITS-1:0]   addr,
   output logic      [COUNT_BITS-1:0]      data,
   output logic                            busy
);
   import bwh_pkg::*;

   localparam int DEPTH = 1 << MAX_WORD_BITS;

   logic [COUNT_BITS-1:0]    mem [DEPTH];
   logic [COUNT_BITS-1:0]    rd_data_ff;
   logic                     fwd_hit_ff, fwd_hit_in;
   logic [COUNT_BITS-1:0]    fwd_data_ff;
   logic                     inc_ff;
   logic [MAX_WORD_BITS-1:0] wr_addr_ff;
   logic                     clear_ff;
   logic [MAX_WORD_BITS-1:0] clr_addr_ff;
   logic [COUNT_BITS-1:0]    cur;
   logic [COUNT_BITS-1:0]    wr_data;

   // current entry value, forwarded when the previous write hit it
   always_comb begin
      cur        = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      wr_data    = (cur == '1) ? cur : cur + 1'b1;
      fwd_hit_in = inc_ff && (wr_addr_ff == addr);
   end

   // write port: clearing sweep or increment write-back
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (inc_ff) begin
         mem[wr_addr_ff] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (req.rd) begin
         rd_data_ff  <= mem[addr];
         fwd_data_ff <= wr_data;
         wr_addr_ff  <= addr;
      end
   end

   // control: forwarding, pending increment, clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff  <= 1'b0;
         inc_ff      <= 1'b0;
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         if (req.rd) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         inc_ff <= req.rd && req.inc;
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               clear_ff <= 1'b0;
            end
         end
      end
   end

   assign data = cur;
   assign busy = clear_ff;

   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req.rd && !inc_ff)
      else $error("memory access during clearing sweep");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (req.rd && fwd_hit_in) |=> fwd_hit_ff && $past(inc_ff))
      else $error("forwarding without a pending write");

   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> &$past(clr_addr_ff))
      else $error("clearing sweep ended early");

endmodule

`default_nettype wire

[sv/binary_word_histogram.sv]
// Binary word histogram: counts sliding-window words of a '0'/'1' stream.
// req channel: req_tuser = command, req_tdata = symbol and word index.
// rsp channel: one transaction per read command with the count and error.
// csr channel: write of word_length, always ready.
// A new transaction is accepted every cycle while req_tready is high. A
// counted word push reads its counter from the count memory through the
// registered read port and writes back the incremented value; a push
// to the same word in the next cycle is served by forwarding.
// A read result passes the second stage and the output register to rsp.
// After reset the count memory, 2**MAX_WORD_BITS entries (1024 by default),
// is swept to zero, one entry per cycle; req_tready stays low during it,
// csr writes are taken. The window, error flag and total reset at once.
// A stalled rsp holds its transaction; one more read may wait behind it,
// after which req_tready drops until rsp_tready returns.
// Depends on bwh_pkg, bwh_window and bwh_count_mem.
`default_nettype none

module binary_word_histogram #(
   parameter int MAX_WORD_BITS = bwh_pkg::DEF_MAX_WORD_BITS,
   parameter int COUNT_BITS    = bwh_pkg::DEF_COUNT_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // command
   input  wire logic [bwh_pkg::REQ_USER_W-1:0]  req_tuser,
   // symbol [7:0], word_index [17:8], zero [23:18]
   input  wire logic [bwh_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // value [31:0], error [32], zero [39:33]
   output logic      [bwh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [bwh_pkg::LEN_W-1:0]       csr_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready
);
   import bwh_pkg::*;

   localparam int WIDE_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

   logic [LEN_W-1:0]         word_length_ff;
   cmd_type                  cmd;
   logic [SYM_W-1:0]         symbol;
   logic [WIDX_W-1:0]        word_index;
   logic                     req_acc;
   logic                     win_push, win_count, win_error;
   logic [MAX_WORD_BITS-1:0] win_idx;
   logic [COUNT_BITS-1:0]    win_total;
   mem_req_type              mreq;
   logic [MAX_WORD_BITS-1:0] maddr;
   logic [COUNT_BITS-1:0]    mdata;
   logic                     mbusy;

   logic                     s2_valid_ff;
   cmd_type                  s2_cmd_ff;
   logic                     s2_err_ff;
   logic [COUNT_BITS-1:0]    s2_total_ff;
   logic                     rsp_free, s2_move;
   logic [COUNT_BITS-1:0]    s2_count;
   logic [WIDE_W-1:0]        s2_wide;
   logic [OUT_W-1:0]         s2_value;

   logic                     rsp_valid_ff;
   logic [OUT_W-1:0]         rsp_value_ff;
   logic                     rsp_err_ff;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= WORD_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         word_length_ff <= csr_data;
      end
   end

   // request unpacking and handshake
   always_comb begin
      cmd        = cmd_type'(req_tuser);
      symbol     = req_tdata[SYM_W-1:0];
      word_index = req_tdata[SYM_W+WIDX_W-1:SYM_W];
      rsp_free   = !rsp_valid_ff || rsp_tready;
      s2_move    = s2_valid_ff && rsp_free;
      req_tready = !mbusy && !(s2_valid_ff && !rsp_free);
      req_acc    = req_tvalid && req_tready;
      win_push   = req_acc && (cmd == CMD_PUSH);
   end

   bwh_window #(
      .MAX_WORD_BITS (MAX_WORD_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .push        (win_push),
      .symbol      (symbol),
      .word_length (word_length_ff),
      .count       (win_count),
      .idx         (win_idx),
      .error       (win_error),
      .total       (win_total)
   );

   // memory access for counted pushes and word reads
   always_comb begin
      mreq.inc = (cmd == CMD_PUSH);
      mreq.rd  = req_acc && ((win_push && win_count) || (cmd == CMD_READ_WORD));
      maddr    = (cmd == CMD_PUSH) ? win_idx : MAX_WORD_BITS'(word_index);
   end

   bwh_count_mem #(
      .MAX_WORD_BITS (MAX_WORD_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_count_mem (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .addr  (maddr),
      .data  (mdata),
      .busy  (mbusy)
   );

   // second stage: read transaction waiting for memory data or holding the total
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s2_valid_ff <= (cmd == CMD_READ_WORD) || (cmd == CMD_READ_TOTAL);
      end else if (s2_move) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s2_cmd_ff   <= cmd;
         s2_err_ff   <= win_error;
         s2_total_ff <= win_total;
      end
   end

   // result value, saturated to the output width
   always_comb begin
      s2_count = (s2_cmd_ff == CMD_READ_TOTAL) ? s2_total_ff : mdata;
      s2_wide  = WIDE_W'(s2_count);
      s2_value = (s2_wide > WIDE_W'(OUT_MAX)) ? OUT_MAX : s2_wide[OUT_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_value_ff <= s2_value;
         rsp_err_ff   <= s2_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-OUT_W-1)'(0), rsp_err_ff, rsp_value_ff};

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking testbench of binary_word_histogram. It drives request and
// csr transactions and predicts every read reply, then checks the rsp channel.
// Depends on bwh_pkg and the binary_word_histogram RTL.

module tb_top;
   import bwh_pkg::*;

   localparam int WORD_BITS     = DEF_MAX_WORD_BITS;
   localparam int CNT_BITS      = DEF_COUNT_BITS;
   localparam int TABLE_DEPTH   = 1 << WORD_BITS;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      logic [OUT_W-1:0] value;
      logic             error;
   } count_reply_type;

   logic                  clock;
   logic                  reset;
   // command
   logic [REQ_USER_W-1:0] req_tuser;
   // symbol [7:0], word_index [17:8], zero [23:18]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // value [31:0], error [32], zero [39:33]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [LEN_W-1:0]      csr_data;
   logic                  csr_valid;
   logic                  csr_ready;

   // predicted histogram state
   logic [LEN_W-1:0]     word_len;
   logic [WORD_BITS-1:0] window_reg;
   int                   fill_level;
   bit                   bad_waiting;
   bit                   sticky_error;
   logic [CNT_BITS-1:0]  word_count [TABLE_DEPTH];
   logic [CNT_BITS-1:0]  window_total;

   // replies still owed by the block, oldest first
   count_reply_type expected_replies [$];
   int              error_count = 0;
   int              cycle_count = 0;

   binary_word_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int active_length();
      if (word_len == 0) return 1;
      if (word_len > WORD_BITS) return WORD_BITS;
      return int'(word_len);
   endfunction

   function automatic logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic logic [OUT_W-1:0] clip(logic [CNT_BITS-1:0] c);
      return (c > OUT_MAX) ? OUT_MAX : OUT_W'(c);
   endfunction

   // word held by the newest window at the length in use
   function automatic logic [WIDX_W-1:0] current_word();
      return WIDX_W'(window_reg & ((1 << active_length()) - 1));
   endfunction

   function automatic void clear_histogram();
      word_len     = WORD_LENGTH_RESET;
      window_reg   = '0;
      fill_level   = 0;
      bad_waiting  = 1'b0;
      sticky_error = 1'b0;
      window_total = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) word_count[i] = '0;
   endfunction

   function automatic void shift_in(logic [SYM_W-1:0] sym);
      logic             bit_in;
      logic [WIDX_W-1:0] idx;
      if (sticky_error) return;
      // a bad character enters as a zero and poisons its window
      bit_in = (sym == SYM_ONE);
      if (sym != SYM_ZERO && sym != SYM_ONE) bad_waiting = 1'b1;
      window_reg = {window_reg[WORD_BITS-2:0], bit_in};
      if (fill_level < WORD_BITS) fill_level++;
      if (fill_level >= active_length()) begin
         if (bad_waiting) begin
            sticky_error = 1'b1;
            bad_waiting  = 1'b0;
         end else begin
            idx             = current_word();
            word_count[idx] = bump(word_count[idx]);
            window_total    = bump(window_total);
         end
      end
   endfunction

   function automatic void predict_request(cmd_type cmd, logic [SYM_W-1:0] sym,
                                           logic [WIDX_W-1:0] widx);
      count_reply_type reply;
      reply.error = sticky_error;
      case (cmd)
         CMD_PUSH: begin
            shift_in(sym);
         end
         CMD_READ_WORD: begin
            reply.value = clip(word_count[widx]);
            expected_replies.push_back(reply);
         end
         CMD_READ_TOTAL: begin
            reply.value = clip(window_total);
            expected_replies.push_back(reply);
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- reply checker

   always @(posedge clock) begin
      count_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            error_count++;
            $display("%0t: reply with none pending, expected none, actual %0h/%0b",
                     $time, rsp_tdata[OUT_W-1:0], rsp_tdata[OUT_W]);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want.value) begin
               error_count++;
               $display("%0t: value mismatch, expected %0h, actual %0h",
                        $time, want.value, rsp_tdata[OUT_W-1:0]);
            end
            if (rsp_tdata[OUT_W] !== want.error) begin
               error_count++;
               $display("%0t: error flag mismatch, expected %0b, actual %0b",
                        $time, want.error, rsp_tdata[OUT_W]);
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver stalls

   // alternating stretches with and without back-pressure
   initial begin
      int stall_left;
      int mode_left;
      bit stalls_on;
      stall_left = 0;
      mode_left  = 0;
      stalls_on  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stalls_on = !stalls_on;
            mode_left = $urandom_range(100, 400);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- sender

   // one request transaction; called at a rising edge, returns at the accepting one
   task automatic send_request(cmd_type cmd, logic [SYM_W-1:0] sym,
                               logic [WIDX_W-1:0] widx);
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W - SYM_W - WIDX_W){1'b0}}, widx, sym};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_request(cmd, sym, widx);
   endtask

   task automatic push_char(logic [SYM_W-1:0] sym);
      send_request(CMD_PUSH, sym, WIDX_W'($urandom));
   endtask

   task automatic read_word(logic [WIDX_W-1:0] widx);
      send_request(CMD_READ_WORD, SYM_W'($urandom), widx);
   endtask

   task automatic read_total();
      send_request(CMD_READ_TOTAL, SYM_W'($urandom), WIDX_W'($urandom));
   endtask

   function automatic logic [SYM_W-1:0] random_bit_char();
      return ($urandom_range(0, 1) != 0) ? SYM_ONE : SYM_ZERO;
   endfunction

   task automatic idle_for(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // sender holds off until every reply is in and the pipeline has settled
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] len);
      hold_until_drained();
      csr_data  <= len;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      word_len = len;
   endtask

   // bursts of mostly clean pushes with reads of the live word, random words and the total
   task automatic run_word_traffic(int n_items, int noise_pct);
      int sent;
      int burst;
      int pick;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            sent++;
            if (pick < noise_pct) begin
               push_char(SYM_W'($urandom_range(0, 255)));
            end else if (pick < 62) begin
               push_char(random_bit_char());
            end else if (pick < 76) begin
               read_word(current_word());
            end else if (pick < 88) begin
               read_word(WIDX_W'($urandom_range(0, TABLE_DEPTH - 1)));
            end else if (pick < 95) begin
               read_total();
            end else begin
               // unused command, ignored by the block
               send_request(CMD_NONE, SYM_W'($urandom), WIDX_W'($urandom));
               sent--;
            end
         end
         if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_after_reset();
      read_total();
      read_word('0);
      read_word('1);
      send_request(CMD_NONE, 8'hFF, '1);
      read_total();
   endtask

   // windows that are not yet full, and length changes mid-stream
   task automatic test_partial_window();
      write_length(WORD_LENGTH_RESET);
      push_char(SYM_ONE);
      push_char(SYM_ZERO);
      push_char(SYM_ONE);
      read_total();
      write_length(4'd2);
      push_char(SYM_ONE);
      read_word(current_word());
      read_total();
      // zero length acts as one bit
      write_length(4'd0);
      push_char(SYM_ZERO);
      read_word('0);
      // oversize length acts as the full window
      write_length(4'd15);
      repeat (10) push_char(SYM_ONE);
      read_word('1);
      read_total();
   endtask

   task automatic test_length_sweep();
      logic [LEN_W-1:0] lengths [$];
      lengths = '{4'd1, 4'd10, 4'd0, 4'd15};
      repeat (5) lengths.push_back(LEN_W'($urandom_range(2, 14)));
      foreach (lengths[i]) begin
         write_length(lengths[i]);
         run_word_traffic(110, 0);
      end
   endtask

   // a bad character raises the sticky error; later pushes are ignored
   task automatic test_bad_character();
      read_total();
      push_char(8'h00);
      read_total();
      push_char(8'hFF);
      repeat (3) push_char(SYM_ONE);
      read_word(current_word());
      read_total();
      write_length(4'd3);
      run_word_traffic(60, 25);
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= CMD_NONE;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      clear_histogram();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_partial_window();
      test_length_sweep();
      test_bad_character();

      hold_until_drained();
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
